FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL (clocked on clk, disabled in reset)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Implication or plain property, sampled at clk, off while arst_n is low
`define U8D_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same check written as a trigger and a next-cycle consequence
`define U8D_ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`else

`define U8D_ASSERT(label, prop, msg)
`define U8D_ASSERT_NEXT(label, trig, cons, msg)

`endif

`endif

FILE: rtl/core/u8d_pkg.sv
// Types and constants of the UTF-8 stream decoder
package u8d_pkg;

	localparam int CP_W = 21;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [CP_W-1:0] REPL_RESET = 21'h00FFFD;

	// Byte class bounds
	localparam logic [7:0] ASCII_MAX = 8'h7F;
	localparam logic [7:0] CONT_MAX  = 8'hBF;
	localparam logic [7:0] LEAD2_MAX = 8'hDF;
	localparam logic [7:0] LEAD3_MAX = 8'hEF;
	localparam logic [7:0] LEAD4_MAX = 8'hF7;

	// Input beat
	typedef struct packed {
		logic [7:0] byte_in;
		logic       string_end;
	} src_beat_t;

	// Result beat
	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            is_replacement;
		logic            run_last;
	} res_beat_t;

	// Decoder output: results for one byte plus next state
	typedef struct packed {
		logic [1:0]      res_cnt;
		res_beat_t       res0;
		res_beat_t       res1;
		logic [1:0]      next_pending;
		logic [CP_W-1:0] next_acc;
	} dec_out_t;

endpackage

FILE: rtl/core/u8d_decode.sv
// Combinational decode of one byte against the pending sequence state
module u8d_decode (
	input  u8d_pkg::src_beat_t       beat,
	input  logic [1:0]               pending,
	input  logic [u8d_pkg::CP_W-1:0] acc,
	input  logic [u8d_pkg::CP_W-1:0] repl,
	output u8d_pkg::dec_out_t        dec
);
	import u8d_pkg::*;

	always_comb begin
		logic [7:0]      c;
		logic [1:0]      n;
		logic [1:0]      np;
		logic [CP_W-1:0] na;
		logic [CP_W-1:0] cp0;
		logic [CP_W-1:0] cp1;
		logic            rp0;
		logic            rp1;

		c   = beat.byte_in;
		n   = 2'd0;
		np  = pending;
		na  = acc;
		cp0 = '0;
		cp1 = '0;
		rp0 = 1'b0;
		rp1 = 1'b0;

		// Byte class
		if (c <= ASCII_MAX) begin
			if (pending != 2'd0) begin
				cp0 = repl;
				rp0 = 1'b1;
				n   = 2'd1;
				np  = 2'd0;
			end
			if (n == 2'd0) begin
				cp0 = {13'd0, c};
			end else begin
				cp1 = {13'd0, c};
			end
			n = n + 2'd1;
		end else if (c <= CONT_MAX) begin
			if (pending != 2'd0) begin
				na = {acc[CP_W-7:0], c[5:0]};
				np = pending - 2'd1;
				if (np == 2'd0) begin
					cp0 = na;
					n   = 2'd1;
				end
			end else begin
				cp0 = repl;
				rp0 = 1'b1;
				n   = 2'd1;
			end
		end else if (c <= LEAD2_MAX) begin
			np = 2'd1;
			na = {16'd0, c[4:0]};
		end else if (c <= LEAD3_MAX) begin
			np = 2'd2;
			na = {17'd0, c[3:0]};
		end else if (c <= LEAD4_MAX) begin
			np = 2'd3;
			na = {18'd0, c[2:0]};
		end else begin
			cp0 = repl;
			rp0 = 1'b1;
			n   = 2'd1;
			np  = 2'd0;
		end

		// End of string flushes a truncated sequence
		if (beat.string_end) begin
			if (np != 2'd0) begin
				if (n == 2'd0) begin
					cp0 = repl;
					rp0 = 1'b1;
				end else begin
					cp1 = repl;
					rp1 = 1'b1;
				end
				n = n + 2'd1;
			end
			np = 2'd0;
			na = '0;
		end

		dec.res_cnt             = n;
		dec.res0.code_point     = cp0;
		dec.res0.is_replacement = rp0;
		dec.res0.run_last       = (n == 2'd1);
		dec.res1.code_point     = cp1;
		dec.res1.is_replacement = rp1;
		dec.res1.run_last       = (n == 2'd2);
		dec.next_pending        = np;
		dec.next_acc            = na;
	end

endmodule

FILE: rtl/core/u8d_resq.sv
// Result queue: takes up to two beats per cycle, hands out one
module u8d_resq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [1:0]                 push_cnt,
	input  u8d_pkg::res_beat_t         push0,
	input  u8d_pkg::res_beat_t         push1,
	input  logic                       pop,
	output u8d_pkg::res_beat_t         head,
	output logic [u8d_pkg::QCNT_W-1:0] count
);
	import u8d_pkg::*;

	res_beat_t           ent_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic [QPTR_W-1:0]   wr_ptr_p1;

	assign wr_ptr_p1 = wr_ptr_q + QPTR_W'(1);

	// Entry storage
	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			ent_q[wr_ptr_q] <= push0;
		end
		if (push_cnt == 2'd2) begin
			ent_q[wr_ptr_p1] <= push1;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push_cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push_cnt) - QCNT_W'(pop);
		end
	end

	assign head  = ent_q[rd_ptr_q];
	assign count = count_q;

endmodule

FILE: rtl/core/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder
//
//  channel | valid     | stall     | payload                          | note
//  --------+-----------+-----------+----------------------------------+-----------------
//  src     | src_valid | src_stall | src_beat (byte_in, string_end)   | one byte a beat
//  res     | res_valid | res_stall | res_beat (code_point, flags)     | 0..2 per byte
//  cfg     | cfg_we    | -         | cfg_data (replacement code)      | write only
//
// One byte is taken per cycle while src_stall is low; its first result beat is offered
// once the byte has passed the input register and been written into the result queue.
// A byte sits in the input register, is decoded there and its 0..2 results go
// into a four-entry result queue, which drains one beat per cycle while res_stall is low.
// src_stall rises while the byte in the input register waits for two free
// queue entries. Reset clears the sequence state and loads 0xFFFD as the
// replacement code.
`include "assert_macros.svh"

module utf8_stream_decoder (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       src_valid,
	output logic                       src_stall,
	input  u8d_pkg::src_beat_t         src_beat,
	output logic                       res_valid,
	input  logic                       res_stall,
	output u8d_pkg::res_beat_t         res_beat,
	input  logic                       cfg_we,
	input  logic [u8d_pkg::CP_W-1:0]   cfg_data
);
	import u8d_pkg::*;

	logic              valid_s1;
	src_beat_t         beat_s1;
	logic [1:0]        pending_q;
	logic [CP_W-1:0]   acc_q;
	logic [CP_W-1:0]   repl_q;
	dec_out_t          dec;
	logic [QCNT_W-1:0] q_count;
	logic              room;
	logic              adv_s1;
	logic              src_take;
	logic              res_take;

	// Handshake
	assign room     = (q_count <= QCNT_W'(QDEPTH - 2));
	assign adv_s1   = valid_s1 && room;
	assign src_stall = valid_s1 && !room;
	assign src_take = src_valid && !src_stall;
	assign res_valid = (q_count != '0);
	assign res_take = res_valid && !res_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src_take) begin
			beat_s1 <= src_beat;
		end
	end

	// Sequence state and replacement code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
			acc_q     <= '0;
			repl_q    <= REPL_RESET;
		end else begin
			if (adv_s1) begin
				pending_q <= dec.next_pending;
				acc_q     <= dec.next_acc;
			end
			if (cfg_we) begin
				repl_q <= cfg_data;
			end
		end
	end

	u8d_decode u_decode (
		.beat    (beat_s1),
		.pending (pending_q),
		.acc     (acc_q),
		.repl    (repl_q),
		.dec     (dec)
	);

	u8d_resq u_resq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cnt (adv_s1 ? dec.res_cnt : 2'd0),
		.push0    (dec.res0),
		.push1    (dec.res1),
		.pop      (res_take),
		.head     (res_beat),
		.count    (q_count)
	);

	// Checks
	`U8D_ASSERT(a_q_bound, q_count <= QCNT_W'(QDEPTH), "result queue overfilled")
	`U8D_ASSERT_NEXT(a_end_clears, adv_s1 && beat_s1.string_end, pending_q == 2'd0 && acc_q == '0, "state not cleared at end of string")
	`U8D_ASSERT(a_last_mark, !(adv_s1 && dec.res_cnt == 2'd2) || (!dec.res0.run_last && dec.res1.run_last), "run_last misplaced on a two-result byte")

endmodule

FILE: tb/utf8_stream_decoder_test.sv
// Self-checking testbench of the UTF-8 stream decoder: predicted code points against the results
module utf8_stream_decoder_test;
	timeunit 1ns;
	timeprecision 1ps;

	import u8d_pkg::*;

	// a byte's first result is offered once it has passed the input register and the result queue; allow margin
	localparam int SETTLE_CYCLES = 4;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RESET_CYCLES = 11;

	// Decoder state mirror and the queue of code points still to come
	class decode_scoreboard;
		logic [CP_W-1:0] repl_code;
		logic [1:0]      pending;
		logic [CP_W-1:0] acc;
		res_beat_t       code_q[$];
		int              errors;
		int              checked;
		int              repl_seen;

		function new();
			repl_code = REPL_RESET;
			pending = '0;
			acc = '0;
			errors = 0;
			checked = 0;
			repl_seen = 0;
		endfunction

		function void push_code(logic [CP_W-1:0] cp, logic repl);
			res_beat_t r;
			r.code_point = cp;
			r.is_replacement = repl;
			r.run_last = 1'b0;
			code_q = {code_q, r};
		endfunction

		// Work out the 0..2 results of one accepted byte
		function void note_byte(src_beat_t beat);
			logic [7:0] c;
			int n;
			c = beat.byte_in;
			n = 0;
			if (c <= ASCII_MAX) begin
				// ASCII cuts off a pending sequence with a replacement first
				if (pending != 0) begin
					push_code(repl_code, 1'b1);
					n++;
					pending = '0;
				end
				push_code(CP_W'(c), 1'b0);
				n++;
			end else if (c <= CONT_MAX) begin
				if (pending != 0) begin
					acc = {acc[CP_W-7:0], c[5:0]};
					pending = pending - 2'd1;
					if (pending == 0) begin
						push_code(acc, 1'b0);
						n++;
					end
				end else begin
					// stray continuation
					push_code(repl_code, 1'b1);
					n++;
				end
			end else if (c <= LEAD2_MAX) begin
				pending = 2'd1;
				acc = CP_W'(c[4:0]);
			end else if (c <= LEAD3_MAX) begin
				pending = 2'd2;
				acc = CP_W'(c[3:0]);
			end else if (c <= LEAD4_MAX) begin
				pending = 2'd3;
				acc = CP_W'(c[2:0]);
			end else begin
				// F8..FF never valid
				push_code(repl_code, 1'b1);
				n++;
				pending = '0;
			end
			// end of string flushes a truncated sequence
			if (beat.string_end) begin
				if (pending != 0) begin
					push_code(repl_code, 1'b1);
					n++;
				end
				pending = '0;
				acc = '0;
			end
			if (n > 0) begin
				code_q[code_q.size() - 1].run_last = 1'b1;
			end
		endfunction

		task report(string msg);
			$display("%0t ns: MISMATCH %s", $realtime, msg);
			errors++;
		endtask

		// Compare one result beat with the oldest prediction
		task check_result(res_beat_t got);
			res_beat_t want;
			if (code_q.size() == 0) begin
				report($sformatf("unexpected result cp=%06h repl=%0b last=%0b",
					got.code_point, got.is_replacement, got.run_last));
			end else begin
				want = code_q.pop_front();
				checked++;
				if (want.is_replacement)
					repl_seen++;
				if (got.code_point !== want.code_point)
					report($sformatf("code_point %06h, want %06h", got.code_point,
						want.code_point));
				if (got.is_replacement !== want.is_replacement)
					report($sformatf("is_replacement %0b, want %0b (cp %06h)",
						got.is_replacement, want.is_replacement, want.code_point));
				if (got.run_last !== want.run_last)
					report($sformatf("run_last %0b, want %0b (cp %06h)", got.run_last,
						want.run_last, want.code_point));
			end
		endtask
	endclass

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            src_valid = 1'b0;
	logic            src_stall;
	src_beat_t       src_beat = '0;
	logic            res_valid;
	logic            res_stall = 1'b0;
	res_beat_t       res_beat;
	logic            cfg_we = 1'b0;
	logic [CP_W-1:0] cfg_data = '0;

	decode_scoreboard sb = new();

	bit quiet_src = 1'b0;
	bit quiet_res = 1'b0;
	int bytes_sent = 0;
	int strings_ended = 0;
	int cfg_writes = 0;
	int idle_cycles = 0;

	utf8_stream_decoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_beat  (src_beat),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_beat  (res_beat),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Result side: random stall before each beat
	initial begin
		int n;
		forever begin
			n = quiet_res ? 0 : $urandom_range(0, 3);
			if (n > 0) begin
				res_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			res_stall <= 1'b0;
			do @(posedge clk); while (!(res_valid && !res_stall));
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sb.check_result(res_beat);
	end

	// Watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((src_valid && !src_stall) || (res_valid && !res_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t ns: watchdog expired, %0d results outstanding", $realtime,
					sb.code_q.size());
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Offer one byte after a random gap, return at the edge that takes it
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = quiet_src ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_beat <= '{byte_in: b, string_end: last};
		do @(posedge clk); while (!(src_valid && !src_stall));
		sb.note_byte('{byte_in: b, string_end: last});
		bytes_sent++;
		if (last)
			strings_ended++;
	endtask

	// Stop sending and let every expected result come out
	task automatic drain();
		src_valid <= 1'b0;
		while (sb.code_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_repl(input logic [CP_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.repl_code = v;
		cfg_writes++;
	endtask

	// Byte class extremes and each malformed case
	task automatic run_directed();
		logic [8:0] seq [$];
		seq = '{
			{8'h00, 1'b0}, {8'h7F, 1'b0},                        // ASCII bounds
			{8'hC2, 1'b0}, {8'hA9, 1'b0},                        // two bytes
			{8'hE2, 1'b0}, {8'h82, 1'b0}, {8'hAC, 1'b0},         // three bytes
			{8'hF7, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b0}, // full 21 bits
			{8'h80, 1'b0},                                       // stray continuation
			{8'hF8, 1'b0},                                       // invalid byte
			{8'hC3, 1'b0}, {8'h41, 1'b0},                        // ASCII cuts sequence
			{8'hE2, 1'b0}, {8'hC3, 1'b0}, {8'hA9, 1'b0},         // lead restarts
			{8'hF0, 1'b0}, {8'h90, 1'b0}, {8'hFF, 1'b0},         // invalid mid-sequence
			{8'hE2, 1'b0}, {8'h82, 1'b1},                        // truncated at end
			{8'hDF, 1'b1},                                       // lead as last byte
			{8'h41, 1'b1}
		};
		foreach (seq[i])
			send_byte(seq[i][8:1], seq[i][0]);
	endtask

	// Mostly well-formed sequences, some truncated ones and raw noise
	task automatic run_random(input int count);
		int done;
		int kind;
		int len;
		int ncont;
		logic [7:0] lead;
		logic end_here;
		done = 0;
		while (done < count) begin
			if ($urandom_range(0, 40) == 0) begin
				quiet_src = ($urandom_range(0, 3) == 0);
				quiet_res = ($urandom_range(0, 3) == 0);
			end
			kind = $urandom_range(0, 99);
			if (kind < 85) begin
				len = $urandom_range(1, 4);
				if (kind < 75)
					ncont = len - 1;
				else
					ncont = (len > 1) ? $urandom_range(0, len - 2) : 0;
				case (len)
					1: lead = 8'($urandom_range(8'h00, 8'h7F));
					2: lead = 8'($urandom_range(8'hC0, 8'hDF));
					3: lead = 8'($urandom_range(8'hE0, 8'hEF));
					default: lead = 8'($urandom_range(8'hF0, 8'hF7));
				endcase
				end_here = (kind < 75) ? ($urandom_range(0, 7) == 0)
					: ($urandom_range(0, 2) == 0);
				send_byte(lead, end_here && ncont == 0);
				for (int k = 0; k < ncont; k++)
					send_byte(8'($urandom_range(8'h80, 8'hBF)), end_here && k == ncont - 1);
				done += ncont + 1;
			end else begin
				send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
				done++;
			end
		end
		quiet_src = 1'b0;
		quiet_res = 1'b0;
	endtask

	// Main sequence
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset replacement code
		run_directed();
		run_random(300);
		drain();

		write_repl('0);
		run_random(300);
		drain();

		write_repl('1);
		run_directed();
		run_random(300);
		drain();

		write_repl(CP_W'($urandom_range(0, 21'h1FFFFF)));
		run_random(450);
		drain();

		if (sb.code_q.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.code_q.size()));

		$display("covered %0d bytes in %0d ended strings, %0d results checked",
			bytes_sent, strings_ended, sb.checked);
		$display("%0d replacements under %0d written replacement codes, %0d mismatches",
			sb.repl_seen, cfg_writes, sb.errors);
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/u8d_pkg.sv
rtl/core/u8d_decode.sv
rtl/core/u8d_resq.sv
rtl/core/utf8_stream_decoder.sv
tb/utf8_stream_decoder_test.sv
